@@ hdl/szp_pkg.sv @@
// ----------------------------------------------------------------------------
// szp_pkg
// Shared widths, fixed-point constants, CORDIC arctangent table and the
// rounding helper of the solar zenith position core.
// ----------------------------------------------------------------------------
package szp_pkg;

	// Parameter defaults
	localparam int ANGLE_FRAC_BITS_DFLT = 13;
	localparam int CORDIC_STAGES_DFLT   = 16;

	// Working precision: 30 fraction bits
	localparam int WF = 30;

	// Field widths
	localparam int DAY_W  = 9;
	localparam int MIN_W  = 11;
	localparam int LAT_W  = 15;
	localparam int DECL_W = 13;
	localparam int HA_W   = 16;
	localparam int COS_W  = 16;
	localparam int ZEN_W  = 15;
	localparam int ALT_W  = 15;
	localparam int AM_W   = 16;

	// Internal widths
	localparam int AW        = 34;  // angles with 30 fraction bits
	localparam int TW        = 32;  // sine and cosine values
	localparam int VW        = 34;  // vectoring CORDIC x/y
	localparam int PD_W      = 36;  // day times radians-per-day product
	localparam int ROOT_BITS = 31;  // square root result
	localparam int N_W       = 61;  // square root radicand
	localparam int RT_W      = 63;  // square root trial term
	localparam int SQ_W      = 29;  // squared Q1.14 cosine
	localparam int DIV_W     = 15;  // air mass divisor
	localparam int Q_BITS    = 23;  // air mass quotient
	localparam int ATAN_DEPTH = 24;

	// Register reset
	localparam logic signed [LAT_W-1:0] LAT_RESET = 15'sd5005;

	// Calendar and clock constants
	localparam logic [DAY_W:0] DAY_OFFSET    = 10'd284;
	localparam logic [DAY_W:0] DAYS_PER_YEAR = 10'd365;
	localparam logic [DAY_W:0] DAYS_TWO_YEAR = 10'd730;
	localparam logic signed [MIN_W-1:0] MIN_LIMIT = 11'sd720;

	// Fixed-point constants (30 fraction bits unless noted)
	localparam logic signed [AW-1:0] Q_PI        = 34'sd3373259426;
	localparam logic signed [AW-1:0] Q_HALF_PI   = 34'sd1686629713;
	localparam logic signed [AW-1:0] Q_TWO_PI    = 34'sd6746518852;
	localparam logic signed [VW-1:0] CORDIC_INV_GAIN = 34'sd652032874;
	localparam logic signed [TW-1:0] DECL_AMP    = 32'sd439460742;
	localparam logic [PD_W-1:0]      RAD_PER_DAY_Q32 = 36'd73934453;
	localparam logic signed [AW-1:0] RAD_PER_MIN = 34'sd4685083;

	// Q1.14 cosine limits and air mass constants
	localparam logic signed [COS_W-1:0] C14_ONE = 16'sd16384;
	localparam logic [SQ_W-1:0]         C14_ONE_SQ = 29'd268435456;
	localparam logic [Q_BITS-1:0]       AM_NUM = 23'd4194304;
	localparam logic [AM_W-1:0]         AM_MAX = 16'd65535;

	// atan(2^-i) with 30 fraction bits
	localparam logic signed [AW-1:0] ATAN_TAB [ATAN_DEPTH] = '{
		34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
		34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
		34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
		34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
		34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
		34'sd1024,      34'sd512,       34'sd256,       34'sd128
	};

	// Shift right by sh, rounding half away from zero (sh >= 1)
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
			input int unsigned sh);
		logic signed [63:0] half;
		logic signed [63:0] adj;
		half = 64'sd1 <<< (sh - 1);
		adj  = v + half - ((v < 0) ? 64'sd1 : 64'sd0);
		return adj >>> sh;
	endfunction

endpackage

@@ hdl/szp_if.sv @@
// ----------------------------------------------------------------------------
// szp channel interfaces
// Request channels of the solar zenith position core: time sample in,
// position result out, latitude register write.
// ----------------------------------------------------------------------------
interface szp_sample_if;
	import szp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [DAY_W-1:0]        day_of_year;
	logic signed [MIN_W-1:0] minutes_from_noon;
	modport source (output valid, day_of_year, minutes_from_noon, input ready);
	modport sink   (input valid, day_of_year, minutes_from_noon, output ready);
endinterface

interface szp_result_if;
	import szp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DECL_W-1:0] declination;
	logic signed [HA_W-1:0]   hour_angle;
	logic signed [COS_W-1:0]  cos_zenith;
	logic [ZEN_W-1:0]         zenith_angle;
	logic signed [ALT_W-1:0]  altitude;
	logic [AM_W-1:0]          air_mass;
	logic                     below_horizon;
	modport source (output valid, declination, hour_angle, cos_zenith, zenith_angle,
		altitude, air_mass, below_horizon, input ready);
	modport sink   (input valid, declination, hour_angle, cos_zenith, zenith_angle,
		altitude, air_mass, below_horizon, output ready);
endinterface

interface szp_cfg_if;
	import szp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [LAT_W-1:0] latitude;
	modport source (output valid, latitude, input ready);
	modport sink   (input valid, latitude, output ready);
endinterface

@@ hdl/szp_cordic_rot.sv @@
// ----------------------------------------------------------------------------
// szp_cordic_rot
// Pipelined rotation CORDIC: sine and cosine of an angle in (-2pi, 2pi).
// Accepts one angle per cycle while en is high.
// ----------------------------------------------------------------------------
module szp_cordic_rot #(
	parameter int STAGES = szp_pkg::CORDIC_STAGES_DFLT
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [szp_pkg::AW-1:0]  angle,
	output logic signed [szp_pkg::TW-1:0]  sin_val,
	output logic signed [szp_pkg::TW-1:0]  cos_val
);
	import szp_pkg::*;

	localparam int XW = TW + 1;

	logic signed [AW-1:0] wrap_s1;
	logic signed [AW-1:0] fold_s2;
	logic                 neg_s2;
	logic signed [XW-1:0] x_s [STAGES];
	logic signed [XW-1:0] y_s [STAGES];
	logic signed [AW-1:0] z_s [STAGES];
	logic                 neg_s [STAGES];

	// Wrap into [-pi, pi], then fold into [-pi/2, pi/2] with a sign flip
	always_ff @(posedge clk) begin
		if (en) begin
			if (angle > Q_PI) wrap_s1 <= angle - Q_TWO_PI;
			else if (angle < -Q_PI) wrap_s1 <= angle + Q_TWO_PI;
			else wrap_s1 <= angle;
			if (wrap_s1 > Q_HALF_PI) begin
				fold_s2 <= wrap_s1 - Q_PI;
				neg_s2  <= 1'b1;
			end else if (wrap_s1 < -Q_HALF_PI) begin
				fold_s2 <= wrap_s1 + Q_PI;
				neg_s2  <= 1'b1;
			end else begin
				fold_s2 <= wrap_s1;
				neg_s2  <= 1'b0;
			end
		end
	end

	// One micro-rotation per stage
	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [XW-1:0] xi, yi;
		logic signed [AW-1:0] zi;
		logic                 ni;
		if (i == 0) begin : g_first
			assign xi = XW'(CORDIC_INV_GAIN);
			assign yi = '0;
			assign zi = fold_s2;
			assign ni = neg_s2;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign ni = neg_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_TAB[i];
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_TAB[i];
				end
				neg_s[i] <= ni;
			end
		end
	end

	// Undo the fold
	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= TW'(neg_s[STAGES-1] ? -y_s[STAGES-1] : y_s[STAGES-1]);
			cos_val <= TW'(neg_s[STAGES-1] ? -x_s[STAGES-1] : x_s[STAGES-1]);
		end
	end

endmodule

@@ hdl/szp_cordic_vec.sv @@
// ----------------------------------------------------------------------------
// szp_cordic_vec
// Pipelined vectoring CORDIC: angle of the vector (x, y), x >= 0.
// One vector per cycle while en is high; the angle comes from the last stage.
// ----------------------------------------------------------------------------
module szp_cordic_vec #(
	parameter int STAGES = szp_pkg::CORDIC_STAGES_DFLT
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [szp_pkg::VW-1:0] x_in,
	input  logic signed [szp_pkg::VW-1:0] y_in,
	output logic signed [szp_pkg::AW-1:0] angle
);
	import szp_pkg::*;

	logic signed [VW-1:0] x_s [STAGES];
	logic signed [VW-1:0] y_s [STAGES];
	logic signed [AW-1:0] z_s [STAGES];

	// Drive y toward zero, accumulating the rotation
	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [VW-1:0] xi, yi;
		logic signed [AW-1:0] zi;
		if (i == 0) begin : g_first
			assign xi = x_in;
			assign yi = y_in;
			assign zi = '0;
		end else begin : g_next
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + ATAN_TAB[i];
				end else begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - ATAN_TAB[i];
				end
			end
		end
	end

	assign angle = z_s[STAGES-1];

endmodule

@@ hdl/solar_zenith_position_core.sv @@
// ----------------------------------------------------------------------------
// solar_zenith_position_core
// Solar declination, hour angle, zenith cosine, zenith angle, altitude and
// air mass from a day of year and minutes from solar noon.
//
//   channel  dir  payload                                      request when
//   sample   in   day_of_year, minutes_from_noon               valid & ready
//   result   out  declination .. below_horizon (7 fields)      valid & ready
//   cfg      in   latitude                                     valid & ready
//
// One sample enters per cycle while the pipeline is not held; the path runs
// through two rotation CORDICs in series, the 31-step square root and the
// vectoring CORDIC. The whole pipeline advances together: it holds when the
// result register is full and not taken, and sample.ready follows that.
// Reset clears the valid bits and loads the latitude register; cfg is
// always ready.
// ----------------------------------------------------------------------------
module solar_zenith_position_core #(
	parameter int ANGLE_FRAC_BITS = szp_pkg::ANGLE_FRAC_BITS_DFLT,
	parameter int CORDIC_STAGES   = szp_pkg::CORDIC_STAGES_DFLT
) (
	input logic          clk,
	input logic          arst_n,
	szp_sample_if.sink   sample,
	szp_result_if.source result,
	szp_cfg_if.sink      cfg
);
	import szp_pkg::*;

	localparam int SH  = WF - ANGLE_FRAC_BITS;
	localparam int LR  = CORDIC_STAGES + 3;
	localparam int LV  = CORDIC_STAGES;
	localparam int SA  = 3 + LR;
	localparam int SB  = SA + 2 + LR;
	localparam int SC  = SB + 8 + ROOT_BITS;
	localparam int SD  = SC + LV;
	localparam int NST = SD + 2;
	localparam int DH_D = NST - SA - 2;
	localparam int SIDE_D = NST - SC;

	typedef struct packed {
		logic [ROOT_BITS-1:0]    root;
		logic [N_W-1:0]          rem;
		logic [DIV_W-1:0]        dsor;
		logic [DIV_W-1:0]        drem;
		logic [Q_BITS-1:0]       dend;
		logic [Q_BITS-1:0]       quo;
		logic signed [COS_W-1:0] c14;
	} rt_t;

	typedef struct packed {
		logic signed [DECL_W-1:0] decl;
		logic signed [HA_W-1:0]   ha;
	} dh_t;

	typedef struct packed {
		logic signed [COS_W-1:0] c14;
		logic [AM_W-1:0]         am;
		logic                    below;
	} side_t;

	logic                    en;
	logic [NST:1]            vld_s;
	logic signed [LAT_W-1:0] lat_q;
	logic signed [AW-1:0]    lat_ang;

	// Latitude register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_q <= LAT_RESET;
		end else if (cfg.valid) begin
			lat_q <= cfg.latitude;
		end
	end
	assign lat_ang = AW'(lat_q) <<< SH;

	// Advance everything unless the result register is stalled
	assign en = !vld_s[NST] || result.ready;
	assign sample.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], sample.valid};
		end
	end

	// Front end: day reduction, minute clamp, scaling products
	logic [DAY_W:0]          dsum;
	logic [DAY_W-1:0]        k_s1;
	logic signed [MIN_W-1:0] mins_s1;
	logic [PD_W-1:0]         pday_s2;
	logic signed [AW-1:0]    ha_s2, ha_s3;
	logic signed [AW-1:0]    dang_s3;
	logic [PD_W-1:0]         dround;

	assign dsum = DAY_OFFSET + (DAY_W+1)'(sample.day_of_year);
	assign dround = (pday_s2 + PD_W'(2)) >> 2;

	always_ff @(posedge clk) begin
		if (en) begin
			if (dsum >= DAYS_TWO_YEAR) k_s1 <= DAY_W'(dsum - DAYS_TWO_YEAR);
			else if (dsum >= DAYS_PER_YEAR) k_s1 <= DAY_W'(dsum - DAYS_PER_YEAR);
			else k_s1 <= DAY_W'(dsum);
			if (sample.minutes_from_noon > MIN_LIMIT) mins_s1 <= MIN_LIMIT;
			else if (sample.minutes_from_noon < -MIN_LIMIT) mins_s1 <= -MIN_LIMIT;
			else mins_s1 <= sample.minutes_from_noon;
			pday_s2 <= PD_W'(k_s1) * RAD_PER_DAY_Q32;
			ha_s2   <= AW'(mins_s1) * RAD_PER_MIN;
			ha_s3   <= ha_s2;
			if (signed'(AW'(dround)) > Q_PI) dang_s3 <= signed'(AW'(dround)) - Q_TWO_PI;
			else dang_s3 <= signed'(AW'(dround));
		end
	end

	// Sine of the year angle
	logic signed [TW-1:0] sd0;
	szp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_year (
		.clk(clk), .en(en), .angle(dang_s3), .sin_val(sd0), .cos_val()
	);

	// Hold the hour angle until the second CORDIC rank
	logic signed [AW-1:0] ha_dl [LR+2];
	always_ff @(posedge clk) begin
		if (en) begin
			ha_dl[0] <= ha_s3;
			for (int n = 1; n < LR + 2; n++) ha_dl[n] <= ha_dl[n-1];
		end
	end

	// Declination amplitude
	logic signed [63:0]   pdec_s1;
	logic signed [AW-1:0] decl_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			pdec_s1 <= 64'(DECL_AMP) * 64'(sd0);
			decl_s2 <= AW'(rnd_shr(pdec_s1, WF));
		end
	end

	// Declination and hour angle outputs, carried to the end
	dh_t dh_dl [DH_D];
	always_ff @(posedge clk) begin
		if (en) begin
			dh_dl[0].decl <= DECL_W'(rnd_shr(64'(decl_s2), SH));
			dh_dl[0].ha   <= HA_W'(rnd_shr(64'(ha_dl[LR+1]), SH));
			for (int n = 1; n < DH_D; n++) dh_dl[n] <= dh_dl[n-1];
		end
	end

	// Second rank: latitude, declination and hour angle
	logic signed [TW-1:0] sl, cl, sd, cd, ch;
	szp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat (
		.clk(clk), .en(en), .angle(lat_ang), .sin_val(sl), .cos_val(cl)
	);
	szp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_decl (
		.clk(clk), .en(en), .angle(decl_s2), .sin_val(sd), .cos_val(cd)
	);
	szp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_hour (
		.clk(clk), .en(en), .angle(ha_dl[LR+1]), .sin_val(), .cos_val(ch)
	);

	// cos z = sin(lat) sin(decl) + cos(lat) cos(decl) cos(h)
	logic signed [63:0]      p1_s1, p2_s1, p3_s3;
	logic signed [TW-1:0]    q1_s2, q2_s2, q1_s3, q1_s4, q3_s4;
	logic signed [TW-1:0]    ch_s1, ch_s2;
	logic signed [TW:0]      cz_s5;
	logic signed [63:0]      crnd;
	logic signed [COS_W-1:0] c14_s6, c14_s7;
	logic [SQ_W-1:0]         sq_s7;
	logic [Q_BITS-1:0]       dend_s7;
	logic [DIV_W-1:0]        dsor_s7;
	rt_t                     rt_s [ROOT_BITS+1];

	assign crnd = rnd_shr(64'(cz_s5), WF - 14);

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= 64'(sl) * 64'(sd);
			p2_s1 <= 64'(cl) * 64'(cd);
			ch_s1 <= ch;
			q1_s2 <= TW'(rnd_shr(p1_s1, WF));
			q2_s2 <= TW'(rnd_shr(p2_s1, WF));
			ch_s2 <= ch_s1;
			p3_s3 <= 64'(q2_s2) * 64'(ch_s2);
			q1_s3 <= q1_s2;
			q3_s4 <= TW'(rnd_shr(p3_s3, WF));
			q1_s4 <= q1_s3;
			cz_s5 <= (TW+1)'(q1_s4) + (TW+1)'(q3_s4);
			// Narrow to Q1.14 and clamp to [-1, 1]
			if (crnd > 64'(C14_ONE)) c14_s6 <= C14_ONE;
			else if (crnd < -64'(C14_ONE)) c14_s6 <= -C14_ONE;
			else c14_s6 <= COS_W'(crnd);
			// Square for the root, and set up the air mass division
			sq_s7  <= SQ_W'(32'(c14_s6) * 32'(c14_s6));
			c14_s7 <= c14_s6;
			if (c14_s6 > 0) begin
				dend_s7 <= AM_NUM + Q_BITS'(c14_s6[COS_W-1:1]);
				dsor_s7 <= DIV_W'(c14_s6);
			end else begin
				dend_s7 <= '0;
				dsor_s7 <= DIV_W'(1);
			end
			// Radicand 2^60 - (c << 16)^2
			rt_s[0].root <= '0;
			rt_s[0].rem  <= N_W'(C14_ONE_SQ - sq_s7) << 32;
			rt_s[0].dsor <= dsor_s7;
			rt_s[0].drem <= '0;
			rt_s[0].dend <= dend_s7;
			rt_s[0].quo  <= '0;
			rt_s[0].c14  <= c14_s7;
		end
	end

	// Square root one bit a stage; air mass quotient one bit a stage alongside
	for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
		localparam int B = ROOT_BITS - 1 - j;
		logic [RT_W-1:0]      test, remx;
		logic [ROOT_BITS-1:0] root_n;
		logic [N_W-1:0]       rem_n;
		rt_t                  nx;

		always_comb begin
			test = (RT_W'(rt_s[j].root) << (B + 1)) + (RT_W'(1) << (2 * B));
			remx = RT_W'(rt_s[j].rem);
			if (remx >= test) begin
				rem_n  = N_W'(remx - test);
				root_n = rt_s[j].root | (ROOT_BITS'(1) << B);
			end else begin
				rem_n  = rt_s[j].rem;
				root_n = rt_s[j].root;
			end
		end

		if (j < Q_BITS) begin : g_div
			localparam int QB = Q_BITS - 1 - j;
			logic [DIV_W:0] r2;
			assign r2 = {rt_s[j].drem, rt_s[j].dend[QB]};
			always_comb begin
				nx = rt_s[j];
				nx.root = root_n;
				nx.rem  = rem_n;
				if (r2 >= {1'b0, rt_s[j].dsor}) begin
					nx.drem = DIV_W'(r2 - {1'b0, rt_s[j].dsor});
					nx.quo[QB] = 1'b1;
				end else begin
					nx.drem = r2[DIV_W-1:0];
				end
			end
		end else begin : g_pass
			always_comb begin
				nx = rt_s[j];
				nx.root = root_n;
				nx.rem  = rem_n;
			end
		end

		always_ff @(posedge clk) begin
			if (en) rt_s[j+1] <= nx;
		end
	end

	// Altitude: angle of (sqrt(1 - c^2), c)
	logic signed [AW-1:0] alt_raw;
	szp_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec_alt (
		.clk(clk), .en(en),
		.x_in(signed'(VW'(rt_s[ROOT_BITS].root))),
		.y_in(VW'(rt_s[ROOT_BITS].c14) <<< 16),
		.angle(alt_raw)
	);

	// Cosine, air mass and horizon flag, carried to the end
	side_t side_dl [SIDE_D];
	always_ff @(posedge clk) begin
		if (en) begin
			side_dl[0].c14   <= rt_s[ROOT_BITS].c14;
			side_dl[0].below <= (rt_s[ROOT_BITS].c14 <= 0);
			if (rt_s[ROOT_BITS].c14 <= 0) side_dl[0].am <= '0;
			else if (rt_s[ROOT_BITS].quo > Q_BITS'(AM_MAX)) side_dl[0].am <= AM_MAX;
			else side_dl[0].am <= AM_W'(rt_s[ROOT_BITS].quo);
			for (int n = 1; n < SIDE_D; n++) side_dl[n] <= side_dl[n-1];
		end
	end

	// Clamp altitude, derive zenith, round to output precision
	logic signed [AW-1:0]    alt_s1, zen_s1;
	logic signed [63:0]      zrnd;
	logic signed [ALT_W-1:0] alt_s2;
	logic [ZEN_W-1:0]        zen_s2;

	assign zrnd = rnd_shr(64'(zen_s1), SH);

	always_ff @(posedge clk) begin
		if (en) begin
			if (alt_raw > Q_HALF_PI) begin
				alt_s1 <= Q_HALF_PI;
				zen_s1 <= '0;
			end else if (alt_raw < -Q_HALF_PI) begin
				alt_s1 <= -Q_HALF_PI;
				zen_s1 <= Q_HALF_PI + Q_HALF_PI;
			end else begin
				alt_s1 <= alt_raw;
				zen_s1 <= Q_HALF_PI - alt_raw;
			end
			alt_s2 <= ALT_W'(rnd_shr(64'(alt_s1), SH));
			zen_s2 <= (zrnd < 0) ? '0 : ZEN_W'(zrnd);
		end
	end

	// Result register
	assign result.valid         = vld_s[NST];
	assign result.declination   = dh_dl[DH_D-1].decl;
	assign result.hour_angle    = dh_dl[DH_D-1].ha;
	assign result.cos_zenith    = side_dl[SIDE_D-1].c14;
	assign result.zenith_angle  = zen_s2;
	assign result.altitude      = alt_s2;
	assign result.air_mass      = side_dl[SIDE_D-1].am;
	assign result.below_horizon = side_dl[SIDE_D-1].below;

endmodule

@@ bench/tb_solar_zenith_position_core.sv @@
// ----------------------------------------------------------------------------
// tb_solar_zenith_position_core
// Self-checking bench for the solar zenith position core. A directed table
// of time samples is followed by random samples over several latitudes;
// every result is compared with a behavioral CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_solar_zenith_position_core;
	import szp_pkg::*;

	localparam int LATENCY   = 3 * CORDIC_STAGES_DFLT + 52;
	localparam int N_RANDOM  = 1500;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic signed [DECL_W-1:0] declination;
		logic signed [HA_W-1:0]   hour_angle;
		logic signed [COS_W-1:0]  cos_zenith;
		logic [ZEN_W-1:0]         zenith_angle;
		logic signed [ALT_W-1:0]  altitude;
		logic [AM_W-1:0]          air_mass;
		logic                     below_horizon;
	} position_t;

	typedef struct {
		logic [DAY_W-1:0]        day;
		logic signed [MIN_W-1:0] mins;
		bit                      typed;
		logic [AM_W-1:0]         am;
		logic                    below;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	szp_sample_if sample ();
	szp_result_if result ();
	szp_cfg_if    cfg ();

	solar_zenith_position_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	always #1 clk = ~clk;

	logic signed [LAT_W-1:0] latitude_q = LAT_RESET;
	position_t pos_queue [$];
	int  err_count = 0;
	longint cycles = 0;
	bit  hold_off = 1'b0;

	// ---- predictor helpers ----
	function automatic longint asr_f(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shift(longint v, int s);
		longint m;
		if (s <= 0) return v;
		m = (v < 0) ? -v : v;
		m = (m + (longint'(1) << (s - 1))) >> s;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return round_shift(a * b, WF);
	endfunction

	function automatic longint tab_atan(int i);
		return longint'(ATAN_TAB[i]);
	endfunction

	function automatic void rotate_sincos(longint a, output longint s, output longint c);
		longint x, y, z, t;
		bit neg;
		x = longint'(CORDIC_INV_GAIN);
		y = 0;
		neg = 0;
		z = a % longint'(Q_TWO_PI);
		if (z > longint'(Q_PI)) z -= longint'(Q_TWO_PI);
		if (z < -longint'(Q_PI)) z += longint'(Q_TWO_PI);
		if (z > longint'(Q_HALF_PI)) begin
			z -= longint'(Q_PI); neg = 1;
		end else if (z < -longint'(Q_HALF_PI)) begin
			z += longint'(Q_PI); neg = 1;
		end
		for (int i = 0; i < CORDIC_STAGES_DFLT; i++) begin
			if (z >= 0) begin
				t = x - asr_f(y, i); y = y + asr_f(x, i); x = t; z -= tab_atan(i);
			end else begin
				t = x + asr_f(y, i); y = y - asr_f(x, i); x = t; z += tab_atan(i);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic longint vector_atan(longint x, longint y);
		longint z, t;
		z = 0;
		for (int i = 0; i < CORDIC_STAGES_DFLT; i++) begin
			if (y >= 0) begin
				t = x + asr_f(y, i); y = y - asr_f(x, i); x = t; z += tab_atan(i);
			end else begin
				t = x - asr_f(y, i); y = y + asr_f(x, i); x = t; z -= tab_atan(i);
			end
		end
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b; r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// Compute the sun position for one time sample at the current latitude
	function automatic position_t sun_position(logic [DAY_W-1:0] day,
			logic signed [MIN_W-1:0] mins_in);
		int sh;
		longint lat, decl, ha, sl, cl, sd, cd, sh0, ch, sd0, cz, c14, alt, zen, mins;
		longint zen_o;
		longint unsigned k, am, xs, yq;
		position_t p;
		sh = WF - ANGLE_FRAC_BITS_DFLT;
		lat = longint'(latitude_q) * (longint'(1) << sh);
		k = (284 + longint'(day)) % 365;
		decl = longint'((k * longint'(RAD_PER_DAY_Q32) + 2) >> 2);
		if (decl > longint'(Q_PI)) decl -= longint'(Q_TWO_PI);
		rotate_sincos(decl, sd0, cd);
		decl = fx_mul(longint'(DECL_AMP), sd0);
		mins = longint'(mins_in);
		if (mins > 720) mins = 720;
		if (mins < -720) mins = -720;
		ha = mins * longint'(RAD_PER_MIN);
		rotate_sincos(lat, sl, cl);
		rotate_sincos(decl, sd, cd);
		rotate_sincos(ha, sh0, ch);
		cz = fx_mul(sl, sd) + fx_mul(fx_mul(cl, cd), ch);
		c14 = round_shift(cz, WF - 14);
		if (c14 > 16384) c14 = 16384;
		if (c14 < -16384) c14 = -16384;
		yq = longint'((c14 < 0) ? -c14 : c14) << 16;
		xs = int_sqrt((64'd1 << 60) - yq * yq);
		alt = vector_atan(longint'(xs), c14 * 65536);
		if (alt > longint'(Q_HALF_PI)) alt = longint'(Q_HALF_PI);
		if (alt < -longint'(Q_HALF_PI)) alt = -longint'(Q_HALF_PI);
		zen = longint'(Q_HALF_PI) - alt;
		if (c14 <= 0) am = 0;
		else begin
			am = ((64'd1 << 22) + longint'(c14) / 2) / longint'(c14);
			if (am > 65535) am = 65535;
		end
		zen_o = round_shift(zen, sh);
		if (zen_o < 0) zen_o = 0;
		p.declination   = DECL_W'(round_shift(decl, sh));
		p.hour_angle    = HA_W'(round_shift(ha, sh));
		p.cos_zenith    = COS_W'(c14);
		p.zenith_angle  = ZEN_W'(zen_o);
		p.altitude      = ALT_W'(round_shift(alt, sh));
		p.air_mass      = AM_W'(am);
		p.below_horizon = (c14 <= 0);
		return p;
	endfunction

	// ---- directed table ----
	row_t dir_rows [$];

	function automatic row_t mk(int d, int m);
		row_t r;
		r.day = DAY_W'(d); r.mins = MIN_W'(m); r.typed = 0; r.am = 0; r.below = 0;
		return r;
	endfunction

	initial begin
		row_t r;
		dir_rows.push_back(mk(1, 0));
		dir_rows.push_back(mk(366, 0));
		dir_rows.push_back(mk(0, 0));
		dir_rows.push_back(mk(511, 0));
		dir_rows.push_back(mk(367, 300));
		dir_rows.push_back(mk(81, -720));
		dir_rows.push_back(mk(172, 720));
		dir_rows.push_back(mk(355, -1024));
		dir_rows.push_back(mk(100, 1023));
		dir_rows.push_back(mk(255, -1));
		dir_rows.push_back(mk(256, 1));
		dir_rows.push_back(mk(172, 0));
		dir_rows.push_back(mk(355, 0));
		dir_rows.push_back(mk(81, 360));
		dir_rows.push_back(mk(264, -360));
		// Winter midnight at the reset latitude: sun well below the horizon,
		// air mass reads zero
		r = mk(355, 720); r.typed = 1; r.am = 0; r.below = 1;
		dir_rows.push_back(r);
	end

	function automatic logic signed [LAT_W-1:0] rand_latitude();
		return LAT_W'($signed($urandom_range(0, 2 * 12868)) - 12868);
	endfunction

	// ---- cycle counter and timeout ----
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_solar_zenith_position_core NOT OK");
			$finish;
		end
	end

	// ---- result side: random stalls and long hold-off ----
	int stall_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_left   = 0;
		end else if (hold_off) begin
			result.ready <= 1'b0;
		end else if (result.valid && result.ready) begin
			stall_left = $urandom_range(0, 4);
			result.ready <= (stall_left == 0);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			result.ready <= (stall_left == 0);
		end else begin
			result.ready <= 1'b1;
		end
	end

	// Long receiver stall while the sender keeps offering
	initial begin
		wait (arst_n);
		repeat (400) @(posedge clk);
		hold_off <= 1'b1;
		repeat (3 * LATENCY) @(posedge clk);
		hold_off <= 1'b0;
	end

	// ---- check each accepted result ----
	always @(posedge clk) begin
		position_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got.declination   = result.declination;
			got.hour_angle    = result.hour_angle;
			got.cos_zenith    = result.cos_zenith;
			got.zenith_angle  = result.zenith_angle;
			got.altitude      = result.altitude;
			got.air_mass      = result.air_mass;
			got.below_horizon = result.below_horizon;
			if (pos_queue.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("unexpected result %p", got);
			end else begin
				want = pos_queue.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= 10) $display("mismatch: expected %p actual %p", want, got);
				end
			end
		end
	end

	// ---- sample driver ----
	task automatic send_sample(logic [DAY_W-1:0] d, logic signed [MIN_W-1:0] m);
		int gap;
		gap = $urandom_range(0, 4);
		if ($urandom_range(0, 9) < 3) gap = 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid             <= 1'b1;
		sample.day_of_year       <= d;
		sample.minutes_from_noon <= m;
		pos_queue.push_back(sun_position(d, m));
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (pos_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_latitude(logic signed [LAT_W-1:0] v);
		cfg.valid    <= 1'b1;
		cfg.latitude <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid  <= 1'b0;
		latitude_q = v;
	endtask

	// ---- main sequence ----
	initial begin
		logic signed [LAT_W-1:0] lat_set [6];
		int d, m;
		sample.valid             = 1'b0;
		sample.day_of_year       = '0;
		sample.minutes_from_noon = '0;
		cfg.valid                = 1'b0;
		cfg.latitude             = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset latitude
		foreach (dir_rows[i]) begin
			send_sample(dir_rows[i].day, dir_rows[i].mins);
			if (dir_rows[i].typed) begin
				pos_queue[$].air_mass      = dir_rows[i].am;
				pos_queue[$].below_horizon = dir_rows[i].below;
			end
		end
		drain();

		lat_set[0] = 15'sd12868;
		lat_set[1] = -15'sd12868;
		lat_set[2] = 15'sd0;
		lat_set[3] = rand_latitude();
		lat_set[4] = rand_latitude();
		lat_set[5] = LAT_RESET;
		for (int ph = 0; ph < 6; ph++) begin
			write_latitude(lat_set[ph]);
			for (int n = 0; n < N_RANDOM / 6; n++) begin
				if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 511);
				else d = $urandom_range(1, 366);
				if ($urandom_range(0, 19) == 0) m = $signed($urandom_range(0, 2047)) - 1024;
				else m = $signed($urandom_range(0, 1440)) - 720;
				send_sample(DAY_W'(d), MIN_W'(m));
				// Pause the sender until the pipeline has emptied
				if (ph == 3 && n == 50) begin
					sample.valid <= 1'b0;
					while (pos_queue.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		if (err_count == 0 && pos_queue.size() == 0) begin
			$display("tb_solar_zenith_position_core OK");
		end else begin
			$display("tb_solar_zenith_position_core NOT OK");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/szp_pkg.sv
hdl/szp_if.sv
hdl/szp_cordic_rot.sv
hdl/szp_cordic_vec.sv
hdl/solar_zenith_position_core.sv
bench/tb_solar_zenith_position_core.sv
